[src/fsmr_pkg.sv]
package fsmr_pkg;

    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int SLOTS_DEF        = 4;

    typedef enum logic [2:0] {
        OP_WRITE   = 3'd0,
        OP_POLL    = 3'd1,
        OP_READ    = 3'd2,
        OP_DONE    = 3'd3,
        OP_BEGIN   = 3'd4
    } t_op;

endpackage

[src/fsmr_buffer.sv]
module fsmr_buffer #(
    parameter int SLOTS        = fsmr_pkg::SLOTS_DEF,
    parameter int SECTOR_BYTES = fsmr_pkg::SECTOR_BYTES_DEF,
    localparam int DEPTH       = SLOTS * SECTOR_BYTES,
    localparam int MEM_AW      = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [MEM_AW-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [MEM_AW-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    // sector data, no reset: stale bytes stay until overwritten
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/flash_sector_mailbox_ring_unit.sv]
// Sector mailbox ring: gathers byte writes into SLOTS sector buffers ahead of
// flash programming, and hands queued sectors to a worker by polling.
//
// Command channel: i_operation and its operands are taken at a rising edge
// with start high and busy low. Exactly one result follows per command, shown
// for one cycle with o_valid high; there is no backpressure on results.
// Configuration: i_cfg_app_base is loaded whenever i_cfg_we is high, and is
// meant to change only while the block is idle.
//
// Sequencing: a command is taken at the transfer and worked in S_EXEC; busy
// stays high until it finishes, so a new command waits for the one before it.
// A write whose fill-pointer slot can serve it, and every other command,
// finishes without a walk. A write that meets a queued slot holding another
// sector steps past it first: a single sector compare checks one slot a
// cycle. A refused write walks all SLOTS slots before its result is given.
// Buffer reads issue the RAM read at the transfer.
//
// Reset: all slots free, both pointers at slot 0, app_base cleared. Buffer
// bytes are not cleared and hold nothing defined until written.
module flash_sector_mailbox_ring_unit #(
    parameter int SECTOR_BYTES = fsmr_pkg::SECTOR_BYTES_DEF,
    parameter int SLOTS        = fsmr_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_app_base,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [23:0] i_offset,
    input  logic [7:0]  i_write_byte,
    input  logic        i_last_byte,
    input  logic [1:0]  i_read_slot,
    input  logic [11:0] i_read_index,
    output logic        o_valid,
    output logic        o_accepted,
    output logic        o_commit_valid,
    output logic [1:0]  o_commit_slot,
    output logic [23:0] o_commit_sector,
    output logic [7:0]  o_read_data,
    output logic        o_all_written
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int POS_W  = $clog2(SECTOR_BYTES);
    localparam int MEM_AW = $clog2(SLOTS * SECTOR_BYTES);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [23:0] SECTOR_MASK = ~24'(SECTOR_BYTES - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] p);
        logic [SLOT_W-1:0] q;
        if (p == LAST_SLOT) begin
            q = '0;
        end else begin
            q = p + SLOT_W'(1);
        end
        return q;
    endfunction

    t_state              r_state, n_state;
    logic [23:0]         r_app_base;
    fsmr_pkg::t_op       r_op;
    logic [23:0]         r_sec_in;
    logic [POS_W-1:0]    r_pos;
    logic [7:0]          r_byte;
    logic                r_rd_ok;
    logic [SLOT_W-1:0]   r_tries, n_tries;
    logic [SLOT_W-1:0]   r_fill, n_fill;
    logic [SLOT_W-1:0]   r_worker, n_worker;
    logic [SLOTS-1:0]    r_queued, n_queued;
    logic [23:0]         r_sector [SLOTS];

    logic                r_valid, n_valid;
    logic                r_acc, n_acc;
    logic                r_cv, n_cv;
    logic [1:0]          r_cs, n_cs;
    logic [23:0]         r_csec, n_csec;
    logic [7:0]          r_rd, n_rd;
    logic                r_all, n_all;

    logic                accept;
    logic                done;
    logic                sector_we;
    logic [SLOT_W-1:0]   rd_idx;
    logic [23:0]         sec_rd;
    logic [23:0]         sum;
    logic [23:0]         ridx_ext;
    logic [SLOT_W-1:0]   rslot;
    logic [MEM_AW-1:0]   mem_waddr;
    logic [MEM_AW-1:0]   mem_raddr;
    logic [7:0]          mem_rdata;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign sum      = r_app_base + i_offset;
    assign ridx_ext = {12'b0, i_read_index};
    assign rslot    = SLOT_W'({3'b0, i_read_slot});
    assign rd_idx   = (r_op == fsmr_pkg::OP_WRITE) ? r_fill : r_worker;
    assign sec_rd   = r_sector[rd_idx];

    assign mem_waddr = MEM_AW'({r_fill, r_pos});
    assign mem_raddr = MEM_AW'({rslot, ridx_ext[POS_W-1:0]});

    fsmr_buffer #(
        .SLOTS        (SLOTS),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_buffer (
        .i_clk   (i_clk),
        .i_we    (sector_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_byte),
        .i_re    (accept),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_tries   = r_tries;
        n_fill    = r_fill;
        n_worker  = r_worker;
        n_queued  = r_queued;
        done      = 1'b0;
        sector_we = 1'b0;
        n_acc     = 1'b0;
        n_cv      = 1'b0;
        n_cs      = '0;
        n_csec    = '0;
        n_rd      = '0;

        if (r_state == S_EXEC) begin
            case (r_op)
                fsmr_pkg::OP_WRITE: begin
                    if (!r_queued[r_fill] || sec_rd == r_sec_in) begin
                        n_queued[r_fill] = 1'b1;
                        sector_we        = 1'b1;
                        n_acc            = 1'b1;
                        done             = 1'b1;
                    end else begin
                        // slot holds another sector: leave it queued, step on
                        n_fill = ring_next(r_fill);
                        if (r_tries == LAST_SLOT) begin
                            done = 1'b1;
                        end else begin
                            n_tries = r_tries + SLOT_W'(1);
                        end
                    end
                end
                fsmr_pkg::OP_POLL: begin
                    if (r_queued[r_worker]) begin
                        n_cv   = 1'b1;
                        n_cs   = 2'(r_worker);
                        n_csec = sec_rd;
                    end else begin
                        n_worker = ring_next(r_worker);
                    end
                    done = 1'b1;
                end
                fsmr_pkg::OP_READ: begin
                    n_rd = r_rd_ok ? mem_rdata : 8'd0;
                    done = 1'b1;
                end
                fsmr_pkg::OP_DONE: begin
                    n_queued[r_worker] = 1'b0;
                    n_worker           = ring_next(r_worker);
                    done               = 1'b1;
                end
                fsmr_pkg::OP_BEGIN: begin
                    n_queued = '0;
                    done     = 1'b1;
                end
                default: begin
                    done = 1'b1;
                end
            endcase
        end

        n_valid = done;
        n_all   = ~|n_queued;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                    n_tries = '0;
                end
            end
            S_EXEC: begin
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_app_base <= '0;
            r_tries    <= '0;
            r_fill     <= '0;
            r_worker   <= '0;
            r_queued   <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tries  <= n_tries;
            r_fill   <= n_fill;
            r_worker <= n_worker;
            r_queued <= n_queued;
            r_valid  <= n_valid;
            if (i_cfg_we) begin
                r_app_base <= i_cfg_app_base;
            end
        end
    end

    // command operands
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= fsmr_pkg::t_op'(i_operation);
            r_sec_in <= sum & SECTOR_MASK;
            r_pos    <= i_offset[POS_W-1:0];
            r_byte   <= i_write_byte;
            r_rd_ok  <= ({3'b0, i_read_slot} < 5'(SLOTS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (sector_we) begin
            r_sector[r_fill] <= r_sec_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_acc  <= n_acc;
            r_cv   <= n_cv;
            r_cs   <= n_cs;
            r_csec <= n_csec;
            r_rd   <= n_rd;
            r_all  <= n_all;
        end
    end

    assign o_valid         = r_valid;
    assign o_accepted      = r_acc;
    assign o_commit_valid  = r_cv;
    assign o_commit_slot   = r_cs;
    assign o_commit_sector = r_csec;
    assign o_read_data     = r_rd;
    assign o_all_written   = r_all;

    // result only comes out once the sequencer is back at rest
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tries <= LAST_SLOT)
        else $error("claim walk ran past a full turn");

    a_acc_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted) |-> (r_op == fsmr_pkg::OP_WRITE))
        else $error("accepted flag on a non-write command");

    a_commit_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_commit_valid) |-> r_queued[r_worker])
        else $error("offered slot is not queued");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not start the sequencer");

endmodule

[bench/tb_flash_sector_mailbox_ring_unit.sv]
`timescale 1ns / 100ps

module tb_flash_sector_mailbox_ring_unit;

    localparam int SLOTS        = fsmr_pkg::SLOTS_DEF;
    localparam int SECTOR_BYTES = fsmr_pkg::SECTOR_BYTES_DEF;
    localparam logic [23:0] POS_MASK = 24'(SECTOR_BYTES - 1);

    // codes the block treats as no-ops
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

    localparam int POOL_SIZE  = 6;
    localparam int PHASES     = 6;
    localparam int PHASE_CMDS = 320;

    typedef struct packed {
        logic        accepted;
        logic        commit_valid;
        logic [1:0]  commit_slot;
        logic [23:0] commit_sector;
        logic [7:0]  read_data;
        logic        all_written;
    } ring_result_t;

    class mailbox_ring_scoreboard;
        logic [23:0]  app_base;
        bit           claimed [SLOTS];
        logic [23:0]  slot_addr [SLOTS];
        logic [7:0]   shadow_buf [SLOTS*SECTOR_BYTES];
        bit           was_written [SLOTS*SECTOR_BYTES];
        int           written_q [$];
        int unsigned  fill_idx;
        int unsigned  work_idx;
        ring_result_t expected_q [$];
        int errors, n_cmds, n_writes, n_refused, n_commits, n_reads, n_settings;

        function new();
            app_base = '0;
            for (int i = 0; i < SLOTS; i++) begin
                claimed[i]   = 0;
                slot_addr[i] = '0;
            end
            fill_idx = 0;
            work_idx = 0;
            errors = 0; n_cmds = 0; n_writes = 0; n_refused = 0;
            n_commits = 0; n_reads = 0; n_settings = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_command(logic [2:0] op, logic [23:0] offset, logic [7:0] data,
                                   logic [1:0] rslot, logic [11:0] ridx);
            ring_result_t r;
            logic [23:0]  sum;
            logic [23:0]  sect;
            int           pos;
            int           s;
            bit           stored;
            int unsigned  w;
            r = '0;
            w = work_idx;
            n_cmds++;
            case (op)
                fsmr_pkg::OP_WRITE: begin
                    sum    = app_base + offset;
                    sect   = sum & ~POS_MASK;
                    pos    = int'(offset & POS_MASK);
                    stored = 0;
                    n_writes++;
                    for (int t = 0; t < SLOTS; t++) begin
                        if (!stored) begin
                            s = fill_idx;
                            if (!claimed[s]) begin
                                claimed[s]   = 1;
                                slot_addr[s] = sect;
                                stored       = 1;
                            end else if (slot_addr[s] == sect) begin
                                stored = 1;
                            end else begin
                                fill_idx = (s + 1) % SLOTS;
                            end
                        end
                    end
                    if (stored) begin
                        shadow_buf[s*SECTOR_BYTES + pos] = data;
                        if (!was_written[s*SECTOR_BYTES + pos]) begin
                            was_written[s*SECTOR_BYTES + pos] = 1;
                            written_q.push_back(s*SECTOR_BYTES + pos);
                        end
                    end else begin
                        n_refused++;
                    end
                    r.accepted = stored;
                end
                fsmr_pkg::OP_POLL: begin
                    if (claimed[w]) begin
                        r.commit_valid  = 1'b1;
                        r.commit_slot   = 2'(w);
                        r.commit_sector = slot_addr[w];
                        n_commits++;
                    end else begin
                        work_idx = (w + 1) % SLOTS;
                    end
                end
                fsmr_pkg::OP_READ: begin
                    n_reads++;
                    if (int'(rslot) < SLOTS)
                        r.read_data = shadow_buf[int'(rslot)*SECTOR_BYTES +
                                                 (int'(ridx) % SECTOR_BYTES)];
                end
                fsmr_pkg::OP_DONE: begin
                    claimed[w] = 0;
                    work_idx   = (w + 1) % SLOTS;
                end
                fsmr_pkg::OP_BEGIN: begin
                    for (int i = 0; i < SLOTS; i++) claimed[i] = 0;
                end
                default: ;
            endcase
            r.all_written = 1'b1;
            for (int i = 0; i < SLOTS; i++)
                if (claimed[i]) r.all_written = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void mismatch(string field, logic [23:0] exp_v, logic [23:0] act_v);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
            errors++;
        endfunction

        function void check_result(ring_result_t got);
            ring_result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing outstanding, actual %0h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.accepted !== want.accepted)
                mismatch("accepted", 24'(want.accepted), 24'(got.accepted));
            if (got.commit_valid !== want.commit_valid)
                mismatch("commit_valid", 24'(want.commit_valid), 24'(got.commit_valid));
            if (got.commit_slot !== want.commit_slot)
                mismatch("commit_slot", 24'(want.commit_slot), 24'(got.commit_slot));
            if (got.commit_sector !== want.commit_sector)
                mismatch("commit_sector", want.commit_sector, got.commit_sector);
            if (got.read_data !== want.read_data)
                mismatch("read_data", 24'(want.read_data), 24'(got.read_data));
            if (got.all_written !== want.all_written)
                mismatch("all_written", 24'(want.all_written), 24'(got.all_written));
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [23:0] i_cfg_app_base = '0;
    logic        start          = 1'b0;
    logic        busy;
    logic [2:0]  i_operation    = '0;
    logic [23:0] i_offset       = '0;
    logic [7:0]  i_write_byte   = '0;
    logic        i_last_byte    = 1'b0;
    logic [1:0]  i_read_slot    = '0;
    logic [11:0] i_read_index   = '0;
    logic        o_valid;
    logic        o_accepted;
    logic        o_commit_valid;
    logic [1:0]  o_commit_slot;
    logic [23:0] o_commit_sector;
    logic [7:0]  o_read_data;
    logic        o_all_written;

    mailbox_ring_scoreboard sb;
    bit          gaps_on = 1;
    logic [11:0] sector_pool [POOL_SIZE];

    flash_sector_mailbox_ring_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_app_base  (i_cfg_app_base),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_offset        (i_offset),
        .i_write_byte    (i_write_byte),
        .i_last_byte     (i_last_byte),
        .i_read_slot     (i_read_slot),
        .i_read_index    (i_read_index),
        .o_valid         (o_valid),
        .o_accepted      (o_accepted),
        .o_commit_valid  (o_commit_valid),
        .o_commit_slot   (o_commit_slot),
        .o_commit_sector (o_commit_sector),
        .o_read_data     (o_read_data),
        .o_all_written   (o_all_written)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        ring_result_t got;
        if (i_rst_n && o_valid) begin
            got.accepted      = o_accepted;
            got.commit_valid  = o_commit_valid;
            got.commit_slot   = o_commit_slot;
            got.commit_sector = o_commit_sector;
            got.read_data     = o_read_data;
            got.all_written   = o_all_written;
            sb.check_result(got);
        end
    end

    // one command transfer, then an optional gap with start low
    task automatic issue(logic [2:0] op, logic [23:0] off, logic [7:0] data, logic last,
                         logic [1:0] rslot, logic [11:0] ridx);
        start        <= 1'b1;
        i_operation  <= op;
        i_offset     <= off;
        i_write_byte <= data;
        i_last_byte  <= last;
        i_read_slot  <= rslot;
        i_read_index <= ridx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(op, off, data, rslot, ridx);
        if (gaps_on && $urandom_range(99) < 29) begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_app_base(logic [23:0] value);
        i_cfg_we       <= 1'b1;
        i_cfg_app_base <= value;
        @(posedge i_clk);
        sb.app_base = value;
        sb.n_settings++;
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_command();
        int          pick;
        int          addr;
        logic [23:0] off;
        logic [2:0]  op;
        pick = $urandom_range(99);
        off  = 24'($urandom());
        addr = 0;
        if (pick < 55) begin
            op = fsmr_pkg::OP_WRITE;
            if ($urandom_range(9) != 0)
                off = {sector_pool[$urandom_range(POOL_SIZE-1)], 12'($urandom())};
        end else if (pick < 70) begin
            op = fsmr_pkg::OP_POLL;
        end else if (pick < 82) begin
            op = fsmr_pkg::OP_DONE;
        end else if (pick < 94) begin
            // only bytes already written may be read back
            if (sb.written_q.size() == 0) begin
                op = fsmr_pkg::OP_POLL;
            end else begin
                op   = fsmr_pkg::OP_READ;
                addr = sb.written_q[$urandom_range(sb.written_q.size()-1)];
            end
        end else if (pick < 97) begin
            op = fsmr_pkg::OP_BEGIN;
        end else begin
            op = 3'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
        end
        issue(op, off, 8'($urandom()), 1'($urandom()),
              2'(addr / SECTOR_BYTES), 12'(addr % SECTOR_BYTES));
    endtask

    initial begin
        logic [23:0] bases [PHASES];
        sb = new();
        bases[0] = 24'h000000;
        bases[1] = 24'hFFF000;
        bases[2] = 24'($urandom()) & ~POS_MASK;
        bases[3] = 24'hFFFFFF;
        bases[4] = 24'($urandom()) & ~POS_MASK;
        bases[5] = 24'($urandom());

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_app_base(bases[0]);
        // empty ring: poll and done on free slots walk the worker on
        issue(fsmr_pkg::OP_POLL,  24'h000000, 8'h00, 1'b0, 2'd0, 12'h000);
        issue(fsmr_pkg::OP_DONE,  24'h000000, 8'h00, 1'b0, 2'd0, 12'h000);
        // four sectors fill the ring, the fifth is refused, a known sector still lands
        issue(fsmr_pkg::OP_WRITE, 24'h000000, 8'h00, 1'b1, 2'd0, 12'h000);
        issue(fsmr_pkg::OP_WRITE, 24'hFFFFFF, 8'hFF, 1'b1, 2'd3, 12'hFFF);
        issue(fsmr_pkg::OP_WRITE, 24'h001234, 8'hA5, 1'b0, 2'd0, 12'h000);
        issue(fsmr_pkg::OP_WRITE, 24'h002000, 8'h5A, 1'b1, 2'd0, 12'h000);
        issue(fsmr_pkg::OP_WRITE, 24'h003FFF, 8'h3C, 1'b1, 2'd0, 12'h000);
        issue(fsmr_pkg::OP_WRITE, 24'h000010, 8'hC3, 1'b0, 2'd0, 12'h000);
        issue(fsmr_pkg::OP_READ,  24'hFFFFFF, 8'hFF, 1'b1, 2'd0, 12'h000);
        issue(fsmr_pkg::OP_READ,  24'h000000, 8'h00, 1'b0, 2'd1, 12'hFFF);
        issue(fsmr_pkg::OP_READ,  24'h000000, 8'h00, 1'b0, 2'd2, 12'h234);
        issue(fsmr_pkg::OP_READ,  24'h000000, 8'h00, 1'b0, 2'd3, 12'h000);
        for (int i = 0; i < SLOTS; i++) begin
            issue(fsmr_pkg::OP_POLL, 24'h000000, 8'h00, 1'b0, 2'd0, 12'h000);
            issue(fsmr_pkg::OP_DONE, 24'h000000, 8'h00, 1'b0, 2'd0, 12'h000);
        end
        issue(fsmr_pkg::OP_BEGIN, 24'h000000, 8'h00, 1'b0, 2'd0, 12'h000);
        issue(OP_RSVD_FIRST, 24'hFFFFFF, 8'hFF, 1'b1, 2'd3, 12'hFFF);
        issue(OP_RSVD_LAST,  24'h000000, 8'h00, 1'b0, 2'd0, 12'h000);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) set_app_base(bases[p]);
            // a handful of sectors per phase so claims hit and the ring fills up
            for (int k = 0; k < POOL_SIZE; k++) sector_pool[k] = 12'($urandom());
            sector_pool[0] = (p == 1) ? 12'hFFF : 12'h000;
            gaps_on = (p != 2);
            for (int n = 0; n < PHASE_CMDS; n++) random_command();
            drain();
        end

        repeat (10) @(posedge i_clk);
        $display("covered %0d commands: %0d byte writes (%0d refused), %0d commits offered,",
                 sb.n_cmds, sb.n_writes, sb.n_refused, sb.n_commits);
        $display("%0d buffer reads, %0d app_base settings", sb.n_reads, sb.n_settings);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_flash_sector_mailbox_ring_unit OK");
        end else begin
            $display("tb_flash_sector_mailbox_ring_unit NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout, %0d results outstanding", $time, sb.pending());
        $display("tb_flash_sector_mailbox_ring_unit NOT OK");
        $finish;
    end

endmodule
